FILE: hw/rtl/tth_pkg.sv
// Shared types, constants and the hash step for the text token hasher.
// No dependencies; used by every module of the block.
`default_nettype none

package tth_pkg;

   // Only the low 36 bits of the 64-bit FNV state reach the output, and the
   // low bits of a product depend only on the low bits of its operands.
   localparam int SYMBOL_W = 36;

   localparam logic [SYMBOL_W-1:0] SEED_RESET = 36'h484222325;
   // FNV-64 prime 0x100000001B3 reduced modulo 2**36
   localparam logic [SYMBOL_W-1:0] PRIME_LOW  = 36'h1B3;

   localparam int OUT_DEPTH = 4;

   localparam logic [7:0] CHAR_CR         = 8'h0D;
   localparam logic [7:0] CHAR_LF         = 8'h0A;
   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_FF         = 8'h0C;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_APOSTROPHE = 8'h27;
   localparam logic [7:0] CHAR_ZERO       = 8'h30;
   localparam logic [7:0] CHAR_NINE       = 8'h39;
   localparam logic [7:0] CHAR_LOW_A      = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z      = 8'h7A;

   typedef enum logic [1:0] {
      KIND_WORD  = 2'd0,
      KIND_DIGIT = 2'd1,
      KIND_OTHER = 2'd2
   } kind_type;

   typedef struct packed {
      logic                token_valid;
      logic [SYMBOL_W-1:0] symbol_low;
      kind_type            token_kind;
      logic                first_in_paragraph;
      logic                last_result;
   } result_type;

   // Up to two results produced by one accepted byte, in delivery order
   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } push_type;

   // One FNV-1a step on the low bits: xor the byte, multiply by the prime
   function automatic logic [SYMBOL_W-1:0] hash_step(input logic [SYMBOL_W-1:0] h,
                                                     input logic [7:0]          c);
      logic [SYMBOL_W-1:0] x;
      x = h ^ {{(SYMBOL_W-8){1'b0}}, c};
      // 0x1B3 = 256 + 128 + 32 + 16 + 2 + 1
      return (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tth_tokenizer.sv
// Byte classifier, word hash state and paragraph tracking of the token hasher.
// Depends on tth_pkg; produces up to two results per accepted byte.
`default_nettype none

module tth_tokenizer (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire logic [7:0]                   text_byte,
   input  wire logic                         end_of_text,
   input  wire logic [tth_pkg::SYMBOL_W-1:0] seed,
   output tth_pkg::push_type                 push
);

   logic [tth_pkg::SYMBOL_W-1:0] word_hash_ff, word_hash_in;
   logic in_word_ff, in_word_in;
   logic has_letter_ff, has_letter_in;
   logic line_text_ff, line_text_in;
   logic para_nonempty_ff, para_nonempty_in;
   logic blank_pending_ff, blank_pending_in;
   logic new_para_ff, new_para_in;

   logic [7:0] low_char;
   logic [7:0] hash_char;
   logic is_cr, is_lf, letter, wordch, space, digit;
   logic new_para_mid;
   logic [tth_pkg::SYMBOL_W-1:0] word_hash_mid, char_hash;
   logic in_word_mid, has_letter_mid;
   logic t0_v, t1_v, t2_v;
   tth_pkg::result_type tok0, tok1, tok2, bare;

   always_comb begin
      low_char  = text_byte | 8'h20;
      is_cr     = (text_byte == tth_pkg::CHAR_CR);
      is_lf     = (text_byte == tth_pkg::CHAR_LF);
      letter    = (low_char >= tth_pkg::CHAR_LOW_A) && (low_char <= tth_pkg::CHAR_LOW_Z);
      wordch    = letter || (text_byte == tth_pkg::CHAR_APOSTROPHE);
      space     = (text_byte == tth_pkg::CHAR_SPACE) ||
                  ((text_byte >= tth_pkg::CHAR_TAB) && (text_byte <= tth_pkg::CHAR_FF));
      digit     = (text_byte >= tth_pkg::CHAR_ZERO) && (text_byte <= tth_pkg::CHAR_NINE);
      hash_char = letter ? low_char : text_byte;
      char_hash = tth_pkg::hash_step(seed, text_byte);
   end

   // Paragraph tracking and word accumulation; CR leaves everything alone
   always_comb begin
      line_text_in     = line_text_ff;
      para_nonempty_in = para_nonempty_ff;
      blank_pending_in = blank_pending_ff;
      new_para_mid     = new_para_ff;
      word_hash_mid    = word_hash_ff;
      in_word_mid      = in_word_ff;
      has_letter_mid   = has_letter_ff;
      t0_v             = 1'b0;
      t1_v             = 1'b0;
      if (!is_cr) begin
         priority if (is_lf) begin
            if (line_text_ff) begin
               line_text_in     = 1'b0;
               blank_pending_in = 1'b0;
            end else if (para_nonempty_ff) begin
               blank_pending_in = 1'b1;
            end
         end else if (space) begin
            if (!blank_pending_ff) begin
               para_nonempty_in = 1'b1;
            end
         end else begin
            if (blank_pending_ff && para_nonempty_ff) begin
               new_para_mid     = 1'b1;
               blank_pending_in = 1'b0;
            end
            para_nonempty_in = 1'b1;
            line_text_in     = 1'b1;
         end

         if (wordch) begin
            word_hash_mid  = tth_pkg::hash_step(in_word_ff ? word_hash_ff : seed, hash_char);
            in_word_mid    = 1'b1;
            has_letter_mid = (in_word_ff && has_letter_ff) || letter;
         end else begin
            t0_v           = in_word_ff && has_letter_ff;
            in_word_mid    = 1'b0;
            has_letter_mid = 1'b0;
            t1_v           = !space;
         end
      end
      t2_v = end_of_text && in_word_mid && has_letter_mid;
   end

   // Result packing: closed word, then single-character token, then the word
   // flushed by end of text (never with the first two), else a bare end marker
   always_comb begin
      tok0 = '{token_valid: 1'b1, symbol_low: word_hash_ff, token_kind: tth_pkg::KIND_WORD,
               first_in_paragraph: new_para_mid, last_result: 1'b0};
      tok1 = '{token_valid: 1'b1, symbol_low: char_hash,
               token_kind: digit ? tth_pkg::KIND_DIGIT : tth_pkg::KIND_OTHER,
               first_in_paragraph: new_para_mid && !t0_v, last_result: 1'b0};
      tok2 = '{token_valid: 1'b1, symbol_low: word_hash_mid, token_kind: tth_pkg::KIND_WORD,
               first_in_paragraph: new_para_mid, last_result: 1'b0};
      bare = '{token_valid: 1'b0, symbol_low: '0, token_kind: tth_pkg::KIND_WORD,
               first_in_paragraph: 1'b0, last_result: 1'b1};

      push.r0    = tok0;
      push.r1    = tok1;
      push.count = 2'd0;
      priority if (t0_v) begin
         push.count = t1_v ? 2'd2 : 2'd1;
      end else if (t1_v) begin
         push.r0    = tok1;
         push.count = 2'd1;
      end else if (t2_v) begin
         push.r0    = tok2;
         push.count = 2'd1;
      end else if (end_of_text) begin
         push.r0    = bare;
         push.count = 2'd1;
      end else begin
         push.count = 2'd0;
      end
      if (end_of_text) begin
         if (push.count == 2'd2) begin
            push.r1.last_result = 1'b1;
         end else begin
            push.r0.last_result = 1'b1;
         end
      end
   end

   always_comb begin
      word_hash_in  = word_hash_mid;
      in_word_in    = in_word_mid && !end_of_text;
      has_letter_in = has_letter_mid && !end_of_text;
      new_para_in   = end_of_text || (new_para_mid && !(t0_v || t1_v || t2_v));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_word_ff       <= 1'b0;
         has_letter_ff    <= 1'b0;
         line_text_ff     <= 1'b0;
         para_nonempty_ff <= 1'b0;
         blank_pending_ff <= 1'b0;
         new_para_ff      <= 1'b1;
      end else if (accept) begin
         in_word_ff       <= in_word_in;
         has_letter_ff    <= has_letter_in;
         line_text_ff     <= line_text_in && !end_of_text;
         para_nonempty_ff <= para_nonempty_in && !end_of_text;
         blank_pending_ff <= blank_pending_in && !end_of_text;
         new_para_ff      <= new_para_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_hash_ff <= word_hash_in;
      end
   end

`ifndef SYNTHESIS
   // a byte never flags two tokens as paragraph starts
   assert property (@(posedge clock) disable iff (reset)
      (accept && push.count == 2'd2) |-> !(push.r0.first_in_paragraph &&
                                            push.r1.first_in_paragraph))
      else $error("two paragraph-start tokens from one byte");

   // end of text always produces a result and the last one carries the mark
   assert property (@(posedge clock) disable iff (reset)
      (accept && end_of_text) |-> (push.count != 2'd0) &&
         (push.count == 2'd2 ? push.r1.last_result : push.r0.last_result))
      else $error("end of text without final result");

   // after end of text the word state is clear and the next token is flagged
   assert property (@(posedge clock) disable iff (reset)
      (accept && end_of_text) |=> (!in_word_ff && !has_letter_ff && new_para_ff &&
                                   !para_nonempty_ff && !blank_pending_ff))
      else $error("state not cleared after end of text");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/tth_out_fifo.sv
// Small result queue of the token hasher: takes up to two results a cycle,
// hands out one. Depends on tth_pkg.
`default_nettype none

module tth_out_fifo #(
   parameter int DEPTH = tth_pkg::OUT_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tth_pkg::push_type push,
   input  wire logic              pop,
   output tth_pkg::result_type    out_data,
   output logic                   out_valid,
   output logic                   room_for_two
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tth_pkg::result_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_next;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_next      = ptr_inc(wr_ptr_ff);
      wr_ptr_in    = wr_ptr_ff;
      unique case (push.count)
         2'd0:    wr_ptr_in = wr_ptr_ff;
         2'd1:    wr_ptr_in = wr_next;
         2'd2:    wr_ptr_in = ptr_inc(wr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in    = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in     = count_ff + CNT_W'(push.count) - CNT_W'(pop);
      out_valid    = (count_ff != '0);
      out_data     = mem_ff[rd_ptr_ff];
      room_for_two = (count_ff <= CNT_W'(DEPTH - 2));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.r0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.r1;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (CNT_W'(push.count) + count_ff) <= CNT_W'(DEPTH))
      else $error("result queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("pop from empty result queue");

   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff == $past(count_ff) + CNT_W'($past(push.count)) -
                                   CNT_W'($past(pop)))
      else $error("result queue count drift");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/text_token_hasher_core.sv
// Top level of the text token hasher: stream ports, seed register, ready logic.
// Depends on tth_pkg, tth_tokenizer and tth_out_fifo.
`default_nettype none

// Text token hasher. Takes one text byte per cycle on req_ and delivers
// tokens on rsp_, each a 36-bit FNV-1a 64 symbol (low bits; the full symbol
// has top nibble 0xF) with its kind and a paragraph-start flag. A byte is
// classified, hashed and its results written to a result queue in the cycle
// it is accepted; they can be taken on rsp_ from the next cycle. A byte gives
// zero, one or two results, so the sustained rate is one byte per cycle while
// bytes yield at most one result each and rsp_ is not stalled; a byte that
// closes a word and emits a character token gives two results. req_tready
// drops while the result queue (OUT_DEPTH entries, at least 2) has fewer
// than two free slots. The byte carrying req_tlast always yields at least one
// result, the last with rsp_tlast set (a bare marker with token flag low if
// no token), and returns the tokenizer to its start state. Only the low 36
// bits of the seed affect the output. Write csr_ only while the block is idle.
module text_token_hasher_core #(
   parameter int OUT_DEPTH = tth_pkg::OUT_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] text_byte
   input  wire logic        req_tlast,   // end_of_text
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [35:0] symbol_low, [39:36] zero
   output logic [3:0]       rsp_tuser,   // [0] token_valid, [2:1] token_kind,
                                         // [3] first_in_paragraph
   output logic             rsp_tlast,   // last_result
   input  wire logic        csr_we,
   input  wire logic [63:0] csr_wdata    // hash_seed
);

   logic [tth_pkg::SYMBOL_W-1:0] seed_ff;
   logic                         accept;
   logic                         room_for_two;
   tth_pkg::push_type            push;
   tth_pkg::result_type          head;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= tth_pkg::SEED_RESET;
      end else if (csr_we) begin
         seed_ff <= csr_wdata[tth_pkg::SYMBOL_W-1:0];
      end
   end

   assign req_tready = room_for_two;
   assign accept     = req_tvalid && room_for_two;

   tth_tokenizer u_tokenizer (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_byte   (req_tdata),
      .end_of_text (req_tlast),
      .seed        (seed_ff),
      .push        (push)
   );

   tth_pkg::push_type push_gated;

   always_comb begin
      push_gated = push;
      if (!accept) begin
         push_gated.count = 2'd0;
      end
   end

   tth_out_fifo #(
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (push_gated),
      .pop          (rsp_tvalid && rsp_tready),
      .out_data     (head),
      .out_valid    (rsp_tvalid),
      .room_for_two (room_for_two)
   );

   assign rsp_tdata = {4'd0, head.symbol_low};
   assign rsp_tuser = {head.first_in_paragraph, head.token_kind, head.token_valid};
   assign rsp_tlast = head.last_result;

endmodule

`default_nettype wire
